@@ rtl/srrw_pkg.sv @@
`default_nettype none
package srrw_pkg;

  // Opcodes of an input request
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_SLIDE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Result kinds
  localparam logic [1:0] K_REQUEST = 2'd0;
  localparam logic [1:0] K_DELIVER = 2'd1;
  localparam logic [1:0] K_ACCEPT  = 2'd2;
  localparam logic [1:0] K_IGNORE  = 2'd3;

  // Configuration register indexes
  localparam logic REG_FILE_SIZE = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  localparam int OFFSET_W = 32;
  localparam int TIME_W   = 32;
  localparam int TMO_W    = 16;
  localparam int OUT_LEN_W  = 11;
  localparam int OUT_SLOT_W = 5;

  typedef struct packed {
    logic [1:0]            kind;
    logic [OFFSET_W-1:0]   offset;
    logic [OUT_LEN_W-1:0]  len;
    logic [OUT_SLOT_W-1:0] slot;
  } res_t;

  typedef struct packed {
    logic                 in_file;
    logic                 timed_out;
    logic                 offset_hit;
    logic [OUT_LEN_W-1:0] seg_len;
  } eval_t;

endpackage
`default_nettype wire

@@ rtl/selective_repeat_receive_window.sv @@
`default_nettype none
// Flow: an opcode-3 request is taken in idle and starts no scan; tick and data requests walk
//   every window slot, a slide walks until the first slot that has not arrived, and a stall
//   of the result channel holds the walk. One slot a cycle is evaluated while no stall holds it.
// A new request is taken only once the last one is flushed; one result a cycle at most.
// Reset: synchronous, active low; clears window state, flags and tick count, resets config.
//   Request times read as zero until written (per-slot written bits), so no clearing pass.
module selective_repeat_receive_window #(
  parameter int WINDOW_SLOTS  = 32,
  parameter int SEGMENT_BYTES = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_opcode,
  input  wire  [31:0] in_start_offset,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_byte_offset,
  output logic [10:0] out_seg_length,
  output logic [4:0]  out_slot,
  output logic        out_last,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srrw_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int POS_W  = $clog2(WINDOW_SLOTS + 1);
  // wide enough for (2^32 + WINDOW_SLOTS) * SEGMENT_BYTES without wrap
  localparam int OFF_W  = 33 + $clog2(SEGMENT_BYTES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(WINDOW_SLOTS - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  // configuration
  logic [OFFSET_W-1:0] file_size_r, file_size_nxt;
  logic [TMO_W-1:0]    timeout_r, timeout_nxt;

  // window state
  logic [31:0]             next_seg_r, next_seg_nxt;
  logic [OFF_W-1:0]        base_off_r, base_off_nxt;
  logic [SLOT_W-1:0]       ring_base_r, ring_base_nxt;
  logic [WINDOW_SLOTS-1:0] arrived_r, arrived_nxt;
  logic [TIME_W-1:0]       tick_r, tick_nxt;

  // sequencer
  logic [1:0]          state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [OFFSET_W-1:0] start_r, start_nxt;
  logic                found_r, found_nxt;

  // stage A walks window positions and issues the request-time read
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0] a_slot_r, a_slot_nxt;
  logic [OFF_W-1:0]  a_off_r, a_off_nxt;

  // stage B evaluates one slot with the read data
  logic              b_vld_r, b_vld_nxt;
  logic [SLOT_W-1:0] b_slot_r, b_slot_nxt;
  logic [OFF_W-1:0]  b_off_r, b_off_nxt;

  // held result: sent on when the next one is found, or at the flush with its last flag set
  logic pend_vld_r, pend_vld_nxt;
  res_t pend_r, pend_nxt;

  logic out_vld_r, out_vld_nxt;
  res_t out_r, out_nxt;
  logic out_last_r, out_last_nxt;

  logic              rd_en;
  logic [TIME_W-1:0] rt_q;
  logic              rt_wr_en;
  eval_t             ev;

  logic cfg_wr, out_free, a_has, flag_b, need_emit, halt, stall, b_adv, a_adv, scan_done;
  res_t new_res;

  srrw_rtime_mem #(
    .DEPTH (WINDOW_SLOTS),
    .AW    (SLOT_W)
  ) u_rtime (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (a_slot_r),
    .rd_data (rt_q),
    .wr_en   (rt_wr_en),
    .wr_addr (b_slot_r),
    .wr_data (tick_r)
  );

  srrw_seg_eval #(
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .OFF_W         (OFF_W)
  ) u_eval (
    .seg_off       (b_off_r),
    .start_offset  (start_r),
    .file_size     (file_size_r),
    .tick_count    (tick_r),
    .req_time      (rt_q),
    .timeout_ticks (timeout_r),
    .ev            (ev)
  );

  // APB side: no wait states, register chosen by word address
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? 32'(timeout_r) : file_size_r;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_vld_r || out_ready;
  assign a_has    = (pos_r != POS_W'(WINDOW_SLOTS));
  assign flag_b   = arrived_r[b_slot_r];

  always_comb begin
    unique case (op_r)
      OP_TICK:  need_emit = !flag_b && ev.timed_out && ev.in_file;
      OP_DATA:  need_emit = !flag_b && ev.offset_hit && ev.in_file;
      OP_SLIDE: need_emit = flag_b;
      OP_NONE:  need_emit = 1'b0;
    endcase
  end

  always_comb begin
    new_res.offset = b_off_r[OFFSET_W-1:0];
    new_res.len    = ev.seg_len;
    new_res.slot   = OUT_SLOT_W'(b_slot_r);
    unique case (op_r)
      OP_TICK:  new_res.kind = K_REQUEST;
      OP_DATA:  new_res.kind = K_ACCEPT;
      OP_SLIDE: new_res.kind = K_DELIVER;
      OP_NONE:  new_res.kind = K_IGNORE;
    endcase
  end

  // a slide stops at the first slot that has not arrived
  assign halt      = b_vld_r && (op_r == OP_SLIDE) && !flag_b;
  // a new result needs the held one moved out first
  assign stall     = b_vld_r && need_emit && pend_vld_r && !out_free;
  assign b_adv     = b_vld_r && !stall;
  assign a_adv     = (state_r == ST_SCAN) && a_has && (!b_vld_r || b_adv) && !halt;
  assign scan_done = halt || (!a_has && (!b_vld_r || b_adv));
  assign rd_en     = a_adv;

  always_comb begin
    file_size_nxt = file_size_r;
    timeout_nxt   = timeout_r;
    next_seg_nxt  = next_seg_r;
    base_off_nxt  = base_off_r;
    ring_base_nxt = ring_base_r;
    arrived_nxt   = arrived_r;
    tick_nxt      = tick_r;
    state_nxt     = state_r;
    op_nxt        = op_r;
    start_nxt     = start_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    a_slot_nxt    = a_slot_r;
    a_off_nxt     = a_off_r;
    b_vld_nxt     = b_vld_r;
    b_slot_nxt    = b_slot_r;
    b_off_nxt     = b_off_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_vld_nxt   = out_vld_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    rt_wr_en      = 1'b0;

    if (cfg_wr) begin
      unique case (paddr[2])
        REG_FILE_SIZE: file_size_nxt = pwdata;
        REG_TIMEOUT:   timeout_nxt   = pwdata[TMO_W-1:0];
      endcase
    end

    // drop the result once taken
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          start_nxt = in_start_offset;
          if (in_opcode == OP_TICK) begin
            tick_nxt = tick_r + 1'b1;
          end
          if (in_opcode != OP_NONE) begin
            state_nxt  = ST_SCAN;
            pos_nxt    = '0;
            a_slot_nxt = ring_base_r;
            a_off_nxt  = base_off_r;
            found_nxt  = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        if (b_adv && need_emit) begin
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_nxt      = pend_r;
            out_last_nxt = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_nxt     = new_res;
          unique case (op_r)
            OP_TICK: begin
              rt_wr_en = 1'b1;
            end
            OP_DATA: begin
              arrived_nxt[b_slot_r] = 1'b1;
              found_nxt             = 1'b1;
            end
            OP_SLIDE: begin
              arrived_nxt[b_slot_r] = 1'b0;
              rt_wr_en              = 1'b1;
              next_seg_nxt          = next_seg_r + 1'b1;
              // segment number wraps at 32 bits, its offset with it
              base_off_nxt  = (&next_seg_r) ? '0 : base_off_r + OFF_W'(SEGMENT_BYTES);
              ring_base_nxt = slot_inc(b_slot_r);
            end
            OP_NONE: begin
            end
          endcase
        end

        if (a_adv) begin
          b_vld_nxt  = 1'b1;
          b_slot_nxt = a_slot_r;
          b_off_nxt  = a_off_r;
          a_slot_nxt = slot_inc(a_slot_r);
          a_off_nxt  = a_off_r + OFF_W'(SEGMENT_BYTES);
          pos_nxt    = pos_r + 1'b1;
        end else if (b_adv || halt) begin
          b_vld_nxt = 1'b0;
        end

        if (scan_done) begin
          state_nxt = ST_FLUSH;
          b_vld_nxt = 1'b0;
          // data that matched no free slot is reported as ignored
          if (op_r == OP_DATA && !found_r && !(b_adv && need_emit)) begin
            pend_vld_nxt = 1'b1;
            pend_nxt     = '{kind: K_IGNORE, offset: start_r, len: '0, slot: '0};
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
      timeout_r   <= TMO_W'(100);
      next_seg_r  <= '0;
      base_off_r  <= '0;
      ring_base_r <= '0;
      arrived_r   <= '0;
      tick_r      <= '0;
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      b_vld_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      file_size_r <= file_size_nxt;
      timeout_r   <= timeout_nxt;
      next_seg_r  <= next_seg_nxt;
      base_off_r  <= base_off_nxt;
      ring_base_r <= ring_base_nxt;
      arrived_r   <= arrived_nxt;
      tick_r      <= tick_nxt;
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      b_vld_r     <= b_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    start_r    <= start_nxt;
    found_r    <= found_nxt;
    a_slot_r   <= a_slot_nxt;
    a_off_r    <= a_off_nxt;
    b_slot_r   <= b_slot_nxt;
    b_off_r    <= b_off_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_kind        = out_r.kind;
  assign out_byte_offset = out_r.offset;
  assign out_seg_length  = out_r.len;
  assign out_slot        = out_r.slot;
  assign out_last        = out_last_r;

  // evaluation stage only runs during a scan
  a_b_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_SCAN |-> !b_vld_r)
    else $error("evaluation stage busy outside a scan");

  // every held result is sent before the next request is taken
  a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_vld_r)
    else $error("held result left behind at idle");

  // the position counter never runs past the window
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(WINDOW_SLOTS))
    else $error("scan position beyond window");

  // a scan ends in the flush state once the last position is evaluated or a slide halts
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && scan_done |=> state_r == ST_FLUSH)
    else $error("scan did not end in flush");

endmodule
`default_nettype wire

@@ rtl/srrw_rtime_mem.sv @@
`default_nettype none
module srrw_rtime_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          rd_en,
  input  wire  [AW-1:0]                rd_addr,
  output logic [srrw_pkg::TIME_W-1:0]  rd_data,
  input  wire                          wr_en,
  input  wire  [AW-1:0]                wr_addr,
  input  wire  [srrw_pkg::TIME_W-1:0]  wr_data
);
  import srrw_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written_r;

  // An entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= written_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/srrw_seg_eval.sv @@
`default_nettype none
module srrw_seg_eval #(
  parameter int SEGMENT_BYTES = 1024,
  parameter int OFF_W         = 43
) (
  input  wire  [OFF_W-1:0]             seg_off,
  input  wire  [srrw_pkg::OFFSET_W-1:0] start_offset,
  input  wire  [srrw_pkg::OFFSET_W-1:0] file_size,
  input  wire  [srrw_pkg::TIME_W-1:0]   tick_count,
  input  wire  [srrw_pkg::TIME_W-1:0]   req_time,
  input  wire  [srrw_pkg::TMO_W-1:0]    timeout_ticks,
  output srrw_pkg::eval_t               ev
);
  import srrw_pkg::*;

  localparam int LEN_W = $clog2(SEGMENT_BYTES + 1);

  logic [OFFSET_W-1:0] remain;
  logic [LEN_W-1:0]    len;
  logic [TIME_W-1:0]   age;

  always_comb begin
    remain     = file_size - seg_off[OFFSET_W-1:0];
    ev.in_file = seg_off < OFF_W'(file_size);
    // a segment at or past the end of the file has no bytes
    if (!ev.in_file) begin
      len = '0;
    end else if (remain < OFFSET_W'(SEGMENT_BYTES)) begin
      len = remain[LEN_W-1:0];
    end else begin
      len = LEN_W'(SEGMENT_BYTES);
    end
    age = tick_count - req_time;
    ev.timed_out  = age > TIME_W'(timeout_ticks);
    ev.offset_hit = seg_off == OFF_W'(start_offset);
    ev.seg_len    = OUT_LEN_W'(len);
  end

endmodule
`default_nettype wire
